// ===== rtl/core/i2c_register_access_master_assert.svh =====
// assertion macros shared by the i2c register access master rtl
`ifndef I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH

// property must hold at every clock edge out of reset
`define I2CRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define I2CRA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/i2cra_pkg.sv =====
// shared types and constants for the i2c register access master
`default_nettype none

package i2cra_pkg;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  localparam logic [6:0] DEV_ADDR_RST = 7'd104;
  localparam int unsigned BYTE_BITS   = 8;

  typedef enum logic [3:0] {
    SEG_IDLE    = 4'd0,
    SEG_START1  = 4'd1,
    SEG_ADDRW   = 4'd2,
    SEG_ACK1    = 4'd3,
    SEG_REG     = 4'd4,
    SEG_ACK2    = 4'd5,
    SEG_VAL     = 4'd6,
    SEG_ACK3    = 4'd7,
    SEG_START2  = 4'd8,
    SEG_ADDRR   = 4'd9,
    SEG_ACK4    = 4'd10,
    SEG_RDBITS  = 4'd11,
    SEG_RDACK   = 4'd12,
    SEG_STOP    = 4'd13,
    SEG_STOPERR = 4'd14
  } seg_e;

  typedef struct packed {
    seg_e       seg;
    logic [1:0] slot;
    logic [3:0] bit_index;
    logic [7:0] shift_byte;
    logic [7:0] bytes_left;
    logic       op_read;
    logic [7:0] reg_latch;
    logic [7:0] value_latch;
    logic       scl;
    logic       sda;
  } st_t;

  // idle sequencer with both lines released
  localparam st_t ST_RST = '{
    seg: SEG_IDLE, slot: 2'd0, bit_index: 4'd0, shift_byte: 8'd0, bytes_left: 8'd0,
    op_read: 1'b0, reg_latch: 8'd0, value_latch: 8'd0, scl: 1'b1, sda: 1'b1
  };

  typedef struct packed {
    logic       kind;
    logic       is_read;
    logic [7:0] reg_addr;
    logic [7:0] write_value;
    logic [7:0] read_len;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       done_res;
    logic       nack_error;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_register_access_master.sv =====
// top level of the i2c register access master: state, config and result register
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata, tuser = kind (0 tick, 1 command)
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata, tlast = read_last
// cfg       in   cfg_we_i, no wait              cfg_wdata_i = device_address
//
// one item per cycle while m_axis is not stalled; the result of an item is registered
// as it leaves the input register (one step of the slot sequencer)
// reset clears the sequencer to idle with both lines released and address 104
// a stalled result register holds the input register, which stalls s_axis
`default_nettype none

module i2c_register_access_master (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [0] is_read, [8:1] reg_addr, [16:9] write_value, [24:17] read_len,
  // [25] sda_sample, [31:26] zero
  input  wire logic [31:0] s_axis_tdata,
  // [0] kind
  input  wire logic        s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] read_valid,
  // [11:4] read_data, [12] done_res, [13] nack_error, [15:14] zero
  output      logic [15:0] m_axis_tdata,
  output      logic        m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i
);

  logic             in_valid;
  logic             advance;
  i2cra_pkg::item_t item;
  i2cra_pkg::st_t   st_q;
  i2cra_pkg::st_t   st_d;
  i2cra_pkg::res_t  res_d;
  i2cra_pkg::res_t  res_q;
  logic             out_valid_q;
  logic [6:0]       dev_addr_q;
  logic             idle_st;
  logic             done_out;
  logic             res_idle;
  logic             err_out;
  logic             rd_idle_out;
  logic             rd_fields;

  assign advance = in_valid && (!out_valid_q || m_axis_tready);

  i2cra_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (item)
  );

  i2cra_step u_step (
    .st_i       (st_q),
    .item_i     (item),
    .dev_addr_i (dev_addr_q),
    .st_o       (st_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= i2cra_pkg::DEV_ADDR_RST;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q             <= i2cra_pkg::ST_RST;
      out_valid_q      <= 1'b0;
    end else begin
      if (advance) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.read_last;
  assign m_axis_tdata  = {2'b00, res_q.nack_error, res_q.done_res, res_q.read_data,
                          res_q.read_valid, res_q.busy_res, res_q.sda_level,
                          res_q.scl_level};

  assign idle_st     = (st_q.seg == i2cra_pkg::SEG_IDLE);
  assign done_out    = out_valid_q && res_q.done_res;
  assign res_idle    = res_q.scl_level && res_q.sda_level && !res_q.busy_res;
  assign err_out     = out_valid_q && res_q.nack_error;
  assign rd_idle_out = out_valid_q && !res_q.read_valid;
  assign rd_fields   = res_q.read_last || (res_q.read_data != 8'd0);

`include "i2c_register_access_master_assert.svh"

  // idle bus is always released on both lines
  `I2CRA_ASSERT(a_idle_released, idle_st |-> (st_q.scl && st_q.sda), "idle with a line low")
  // a finished transfer leaves the bus released and the sequencer idle
  `I2CRA_ASSERT(a_done_released, done_out |-> res_idle, "done without released bus")
  // an error is only flagged with done
  `I2CRA_NEVER(a_err_no_done, err_out && !res_q.done_res, "nack error without done")
  // byte fields are zero when no byte is presented
  `I2CRA_NEVER(a_rd_fields_zero, rd_idle_out && rd_fields, "read fields set without read valid")

endmodule

`default_nettype wire

// ===== rtl/core/i2cra_in_stage.sv =====
// input register stage that captures one item and unpacks its fields
`default_nettype none

module i2cra_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output      logic          s_ready_o,
  input  wire logic [31:0]   s_data_i,
  input  wire logic          s_user_i,
  input  wire logic          advance_i,
  output      logic          valid_o,
  output      i2cra_pkg::item_t item_o
);

  logic             valid_q;
  i2cra_pkg::item_t item_q;
  i2cra_pkg::item_t item_d;

  assign s_ready_o = !valid_q || advance_i;

  always_comb begin
    item_d.kind        = s_user_i;
    item_d.is_read     = s_data_i[0];
    item_d.reg_addr    = s_data_i[8:1];
    item_d.write_value = s_data_i[16:9];
    item_d.read_len    = s_data_i[24:17];
    item_d.sda_sample  = s_data_i[25];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/core/i2cra_step.sv =====
// next-state and result logic for one delay slot or command
`default_nettype none

module i2cra_step (
  input  wire i2cra_pkg::st_t   st_i,
  input  wire i2cra_pkg::item_t item_i,
  input  wire logic [6:0]       dev_addr_i,
  output      i2cra_pkg::st_t   st_o,
  output      i2cra_pkg::res_t  res_o
);

  function automatic i2cra_pkg::st_t go_seg(input i2cra_pkg::st_t s,
                                            input i2cra_pkg::seg_e g,
                                            input logic [6:0] dev);
    i2cra_pkg::st_t r;
    r           = s;
    r.seg       = g;
    r.slot      = 2'd0;
    r.bit_index = 4'd0;
    case (g)
      i2cra_pkg::SEG_ADDRW:  r.shift_byte = {dev, 1'b0};
      i2cra_pkg::SEG_ADDRR:  r.shift_byte = {dev, 1'b1};
      i2cra_pkg::SEG_REG:    r.shift_byte = s.reg_latch;
      i2cra_pkg::SEG_VAL:    r.shift_byte = s.value_latch;
      i2cra_pkg::SEG_RDBITS: r.shift_byte = 8'd0;
      default:               r.shift_byte = s.shift_byte;
    endcase
    return r;
  endfunction

  i2cra_pkg::st_t  d;
  i2cra_pkg::res_t r;

  always_comb begin
    logic [3:0] bi;
    logic [7:0] sh;
    logic [7:0] bl;
    d  = st_i;
    bi = st_i.bit_index + 4'd1;
    sh = {st_i.shift_byte[6:0], item_i.sda_sample};
    bl = (st_i.bytes_left != 8'd0) ? st_i.bytes_left - 8'd1 : st_i.bytes_left;
    r.read_valid = 1'b0;
    r.read_data  = 8'd0;
    r.read_last  = 1'b0;
    r.done_res   = 1'b0;
    r.nack_error = 1'b0;

    if (item_i.kind == i2cra_pkg::KIND_CMD) begin
      if (st_i.seg == i2cra_pkg::SEG_IDLE) begin
        d.op_read     = item_i.is_read;
        d.reg_latch   = item_i.reg_addr;
        d.value_latch = item_i.write_value;
        d.bytes_left  = item_i.read_len;
        d = go_seg(d, i2cra_pkg::SEG_START1, dev_addr_i);
      end
    end else begin
      case (st_i.seg)
        i2cra_pkg::SEG_START1, i2cra_pkg::SEG_START2: begin
          if (st_i.slot == 2'd0) begin
            d.scl  = 1'b1;
            d.sda  = 1'b1;
            d.slot = 2'd1;
          end else if (st_i.slot == 2'd1) begin
            d.sda  = 1'b0;
            d.slot = 2'd2;
          end else begin
            d.scl = 1'b0;
            d = go_seg(d, (st_i.seg == i2cra_pkg::SEG_START1) ? i2cra_pkg::SEG_ADDRW
                                                              : i2cra_pkg::SEG_ADDRR,
                       dev_addr_i);
          end
        end
        i2cra_pkg::SEG_ADDRW, i2cra_pkg::SEG_REG, i2cra_pkg::SEG_VAL,
        i2cra_pkg::SEG_ADDRR: begin
          if (st_i.slot == 2'd0) begin
            d.sda  = st_i.shift_byte[7];
            d.slot = 2'd1;
          end else if (st_i.slot == 2'd1) begin
            d.scl  = 1'b1;
            d.slot = 2'd2;
          end else begin
            d.scl        = 1'b0;
            d.shift_byte = {st_i.shift_byte[6:0], 1'b0};
            d.bit_index  = bi;
            if (bi >= 4'(i2cra_pkg::BYTE_BITS)) begin
              d = go_seg(d, i2cra_pkg::seg_e'(st_i.seg + 4'd1), dev_addr_i);
            end else begin
              d.slot = 2'd0;
            end
          end
        end
        i2cra_pkg::SEG_ACK1, i2cra_pkg::SEG_ACK2, i2cra_pkg::SEG_ACK3,
        i2cra_pkg::SEG_ACK4: begin
          if (st_i.slot == 2'd0) begin
            d.sda  = 1'b1;
            d.slot = 2'd1;
          end else if (st_i.slot == 2'd1) begin
            d.scl  = 1'b1;
            d.slot = 2'd2;
          end else begin
            d.scl = 1'b0;
            if (item_i.sda_sample) begin
              d = go_seg(d, i2cra_pkg::SEG_STOPERR, dev_addr_i);
            end else if (st_i.seg == i2cra_pkg::SEG_ACK1) begin
              d = go_seg(d, i2cra_pkg::SEG_REG, dev_addr_i);
            end else if (st_i.seg == i2cra_pkg::SEG_ACK2) begin
              d = go_seg(d, st_i.op_read ? i2cra_pkg::SEG_START2 : i2cra_pkg::SEG_VAL,
                         dev_addr_i);
            end else if (st_i.seg == i2cra_pkg::SEG_ACK3) begin
              d = go_seg(d, i2cra_pkg::SEG_STOP, dev_addr_i);
            end else begin
              d = go_seg(d, (st_i.bytes_left != 8'd0) ? i2cra_pkg::SEG_RDBITS
                                                      : i2cra_pkg::SEG_STOP,
                         dev_addr_i);
            end
          end
        end
        i2cra_pkg::SEG_RDBITS: begin
          if (st_i.slot == 2'd0) begin
            d.sda  = 1'b1;
            d.scl  = 1'b1;
            d.slot = 2'd1;
          end else begin
            d.scl        = 1'b0;
            d.shift_byte = sh;
            d.bit_index  = bi;
            d.slot       = 2'd0;
            if (bi >= 4'(i2cra_pkg::BYTE_BITS)) begin
              r.read_valid = 1'b1;
              r.read_data  = sh;
              r.read_last  = (st_i.bytes_left == 8'd1);
              d.seg        = i2cra_pkg::SEG_RDACK;
              d.bit_index  = 4'd0;
            end
          end
        end
        i2cra_pkg::SEG_RDACK: begin
          if (st_i.slot == 2'd0) begin
            d.sda  = (st_i.bytes_left <= 8'd1);
            d.slot = 2'd1;
          end else if (st_i.slot == 2'd1) begin
            d.scl  = 1'b1;
            d.slot = 2'd2;
          end else begin
            d.scl        = 1'b0;
            d.bytes_left = bl;
            d = go_seg(d, (bl != 8'd0) ? i2cra_pkg::SEG_RDBITS : i2cra_pkg::SEG_STOP,
                       dev_addr_i);
          end
        end
        i2cra_pkg::SEG_STOP, i2cra_pkg::SEG_STOPERR: begin
          if (st_i.slot == 2'd0) begin
            d.sda  = 1'b0;
            d.scl  = 1'b1;
            d.slot = 2'd1;
          end else begin
            d.sda        = 1'b1;
            d.scl        = 1'b1;
            r.done_res   = 1'b1;
            r.nack_error = (st_i.seg == i2cra_pkg::SEG_STOPERR);
            d = go_seg(d, i2cra_pkg::SEG_IDLE, dev_addr_i);
          end
        end
        default: begin
          d = go_seg(d, i2cra_pkg::SEG_IDLE, dev_addr_i);
        end
      endcase
    end

    r.scl_level = d.scl;
    r.sda_level = d.sda;
    r.busy_res  = (d.seg != i2cra_pkg::SEG_IDLE);
  end

  assign st_o  = d;
  assign res_o = r;

endmodule

`default_nettype wire

// ===== sim/i2c_register_access_master_checker.sv =====
// checker for the i2c register access master: predicts line levels per item and compares results
`timescale 1ns / 1ps

module i2c_register_access_master_checker
  import i2cra_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,
  input  wire logic        m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  output int               mismatch_count_o,
  output int               pending_o,
  output int               results_o,
  output int               done_o,
  output int               nack_o,
  output int               bytes_o
);

  st_t        bus;
  logic [6:0] dev_addr;
  res_t       line_queue[$];
  item_t      in_item;
  res_t       got_line;
  res_t       want_line;
  int         mismatches;
  int         results;
  int         dones;
  int         nacks;
  int         bytes_seen;

  function automatic void enter_seg(input seg_e seg);
    bus.seg       = seg;
    bus.slot      = 2'd0;
    bus.bit_index = 4'd0;
    case (seg)
      SEG_ADDRW:  bus.shift_byte = {dev_addr, 1'b0};
      SEG_ADDRR:  bus.shift_byte = {dev_addr, 1'b1};
      SEG_REG:    bus.shift_byte = bus.reg_latch;
      SEG_VAL:    bus.shift_byte = bus.value_latch;
      SEG_RDBITS: bus.shift_byte = 8'h00;
      default: ;
    endcase
  endfunction

  function automatic res_t bus_step(input item_t it);
    res_t r;
    r = '0;
    if (it.kind == KIND_CMD) begin
      if (bus.seg == SEG_IDLE) begin
        bus.op_read     = it.is_read;
        bus.reg_latch   = it.reg_addr;
        bus.value_latch = it.write_value;
        bus.bytes_left  = it.read_len;
        enter_seg(SEG_START1);
      end
    end else begin
      case (bus.seg)
        SEG_START1, SEG_START2: begin
          if (bus.slot == 2'd0) begin
            bus.scl  = 1'b1;
            bus.sda  = 1'b1;
            bus.slot = 2'd1;
          end else if (bus.slot == 2'd1) begin
            bus.sda  = 1'b0;
            bus.slot = 2'd2;
          end else begin
            bus.scl = 1'b0;
            enter_seg(bus.seg == SEG_START1 ? SEG_ADDRW : SEG_ADDRR);
          end
        end
        SEG_ADDRW, SEG_REG, SEG_VAL, SEG_ADDRR: begin
          if (bus.slot == 2'd0) begin
            bus.sda  = bus.shift_byte[7];
            bus.slot = 2'd1;
          end else if (bus.slot == 2'd1) begin
            bus.scl  = 1'b1;
            bus.slot = 2'd2;
          end else begin
            bus.scl        = 1'b0;
            bus.shift_byte = {bus.shift_byte[6:0], 1'b0};
            bus.bit_index  = bus.bit_index + 4'd1;
            if (bus.bit_index >= BYTE_BITS) enter_seg(seg_e'(bus.seg + 4'd1));
            else bus.slot = 2'd0;
          end
        end
        SEG_ACK1, SEG_ACK2, SEG_ACK3, SEG_ACK4: begin
          if (bus.slot == 2'd0) begin
            bus.sda  = 1'b1;
            bus.slot = 2'd1;
          end else if (bus.slot == 2'd1) begin
            bus.scl  = 1'b1;
            bus.slot = 2'd2;
          end else begin
            bus.scl = 1'b0;
            if (it.sda_sample) enter_seg(SEG_STOPERR);
            else if (bus.seg == SEG_ACK1) enter_seg(SEG_REG);
            else if (bus.seg == SEG_ACK2) enter_seg(bus.op_read ? SEG_START2 : SEG_VAL);
            else if (bus.seg == SEG_ACK3) enter_seg(SEG_STOP);
            else enter_seg(bus.bytes_left != 8'd0 ? SEG_RDBITS : SEG_STOP);
          end
        end
        SEG_RDBITS: begin
          if (bus.slot == 2'd0) begin
            bus.sda  = 1'b1;
            bus.scl  = 1'b1;
            bus.slot = 2'd1;
          end else begin
            bus.scl        = 1'b0;
            bus.shift_byte = {bus.shift_byte[6:0], it.sda_sample};
            bus.bit_index  = bus.bit_index + 4'd1;
            if (bus.bit_index >= BYTE_BITS) begin
              r.read_valid = 1'b1;
              r.read_data  = bus.shift_byte;
              r.read_last  = (bus.bytes_left == 8'd1);
              enter_seg(SEG_RDACK);
            end else begin
              bus.slot = 2'd0;
            end
          end
        end
        SEG_RDACK: begin
          if (bus.slot == 2'd0) begin
            bus.sda  = (bus.bytes_left <= 8'd1);
            bus.slot = 2'd1;
          end else if (bus.slot == 2'd1) begin
            bus.scl  = 1'b1;
            bus.slot = 2'd2;
          end else begin
            bus.scl = 1'b0;
            if (bus.bytes_left != 8'd0) bus.bytes_left = bus.bytes_left - 8'd1;
            enter_seg(bus.bytes_left != 8'd0 ? SEG_RDBITS : SEG_STOP);
          end
        end
        SEG_STOP, SEG_STOPERR: begin
          if (bus.slot == 2'd0) begin
            bus.sda  = 1'b0;
            bus.scl  = 1'b1;
            bus.slot = 2'd1;
          end else begin
            bus.sda      = 1'b1;
            bus.scl      = 1'b1;
            r.done_res   = 1'b1;
            r.nack_error = (bus.seg == SEG_STOPERR);
            enter_seg(SEG_IDLE);
          end
        end
        default: enter_seg(SEG_IDLE);
      endcase
    end
    r.scl_level = bus.scl;
    r.sda_level = bus.sda;
    r.busy_res  = (bus.seg != SEG_IDLE);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus        = '0;
      bus.seg    = SEG_IDLE;
      bus.scl    = 1'b1;
      bus.sda    = 1'b1;
      dev_addr   = DEV_ADDR_RST;
      line_queue.delete();
      mismatches = 0;
      results    = 0;
      dones      = 0;
      nacks      = 0;
      bytes_seen = 0;
    end else begin
      if (cfg_we_i) dev_addr = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        in_item.kind        = s_axis_tuser;
        in_item.is_read     = s_axis_tdata[0];
        in_item.reg_addr    = s_axis_tdata[8:1];
        in_item.write_value = s_axis_tdata[16:9];
        in_item.read_len    = s_axis_tdata[24:17];
        in_item.sda_sample  = s_axis_tdata[25];
        line_queue.push_back(bus_step(in_item));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_line.scl_level  = m_axis_tdata[0];
        got_line.sda_level  = m_axis_tdata[1];
        got_line.busy_res   = m_axis_tdata[2];
        got_line.read_valid = m_axis_tdata[3];
        got_line.read_data  = m_axis_tdata[11:4];
        got_line.read_last  = m_axis_tlast;
        got_line.done_res   = m_axis_tdata[12];
        got_line.nack_error = m_axis_tdata[13];
        results++;
        if (got_line.done_res) dones++;
        if (got_line.done_res && got_line.nack_error) nacks++;
        if (got_line.read_valid) bytes_seen++;
        if (line_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with no item pending: tdata=%04h tlast=%0b",
                     results, m_axis_tdata, m_axis_tlast);
        end else begin
          want_line = line_queue.pop_front();
          if (got_line !== want_line || m_axis_tdata[15:14] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: exp scl=%0b sda=%0b busy=%0b rv=%0b data=%02h last=%0b",
                        " done=%0b nack=%0b | got scl=%0b sda=%0b busy=%0b rv=%0b data=%02h",
                        " last=%0b done=%0b nack=%0b pad=%0b"},
                       results, want_line.scl_level, want_line.sda_level,
                       want_line.busy_res, want_line.read_valid, want_line.read_data,
                       want_line.read_last, want_line.done_res, want_line.nack_error,
                       got_line.scl_level, got_line.sda_level, got_line.busy_res,
                       got_line.read_valid, got_line.read_data, got_line.read_last,
                       got_line.done_res, got_line.nack_error, m_axis_tdata[15:14]);
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= line_queue.size();
    results_o        <= results;
    done_o           <= dones;
    nack_o           <= nacks;
    bytes_o          <= bytes_seen;
  end

endmodule

// ===== sim/i2c_register_access_master_tb.sv =====
// testbench top for the i2c register access master: clock, reset, bus transaction stimulus, verdict
`timescale 1ns / 1ps

module i2c_register_access_master_tb;
  import i2cra_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic [6:0]  cfg_wdata_i   = '0;

  int mismatches;
  int pending;
  int results;
  int dones;
  int nacks;
  int bytes_read;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int txn_items = 0;
  int txn_count = 0;
  int busy_cmd_pct = 0;

  i2c_register_access_master DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  i2c_register_access_master_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .results_o        (results),
    .done_o           (dones),
    .nack_o           (nacks),
    .bytes_o          (bytes_read)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  initial begin
    #2_000_000;
    $display("timeout with %0d results still pending", pending);
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [31:0] pack_fields(input logic rd, input logic [7:0] reg_a,
                                              input logic [7:0] val, input logic [7:0] len,
                                              input logic sda);
    return {6'b0, sda, len, val, reg_a, rd};
  endfunction

  task automatic push_item(input logic kind, input logic [31:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic push_random(input logic kind);
    push_item(kind, pack_fields(1'($urandom_range(1)), 8'($urandom_range(255)),
                                8'($urandom_range(255)), 8'($urandom_range(255)),
                                1'($urandom_range(1))));
  endtask

  // one tick of a transaction, command fields random, with an occasional ignored command
  task automatic tick(input logic sda);
    if ($urandom_range(99) < busy_cmd_pct) push_random(KIND_CMD);
    push_item(KIND_TICK, pack_fields(1'($urandom_range(1)), 8'($urandom_range(255)),
                                     8'($urandom_range(255)), 8'($urandom_range(255)), sda));
    txn_items++;
  endtask

  task automatic tick_n(input int n);
    repeat (n) tick(1'($urandom_range(1)));
  endtask

  task automatic ack_phase(input int idx, input int nack_at, input bit noisy, output bit aborted);
    logic sda;
    tick_n(2);
    sda = (nack_at == idx) ? 1'b1 : (noisy ? 1'($urandom_range(1)) : 1'b0);
    tick(sda);
    aborted = sda;
    if (aborted) tick_n(2);
  endtask

  task automatic run_transaction(input logic rd, input logic [7:0] reg_a, input logic [7:0] val,
                                 input logic [7:0] len, input int nack_at, input bit noisy,
                                 input bit extremes);
    bit   aborted;
    logic [7:0] rbyte;
    push_item(KIND_CMD, pack_fields(rd, reg_a, val, len, 1'($urandom_range(1))));
    txn_items++;
    txn_count++;
    tick_n(3 + 24);
    ack_phase(1, nack_at, noisy, aborted);
    if (aborted) return;
    tick_n(24);
    ack_phase(2, nack_at, noisy, aborted);
    if (aborted) return;
    if (!rd) begin
      tick_n(24);
      ack_phase(3, nack_at, noisy, aborted);
      if (aborted) return;
    end else begin
      tick_n(3 + 24);
      ack_phase(4, nack_at, noisy, aborted);
      if (aborted) return;
      for (int k = 0; k < len; k++) begin
        rbyte = extremes ? (k[0] ? 8'h00 : 8'hFF) : 8'($urandom_range(255));
        for (int b = 7; b >= 0; b--) begin
          tick(1'($urandom_range(1)));
          tick(rbyte[b]);
        end
        tick_n(3);
      end
    end
    tick_n(2);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [6:0] addr);
    cfg_wdata_i <= addr;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_transaction();
    logic rd;
    logic [7:0] len;
    int nack_at;
    int pick;
    rd   = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 90) len = 8'($urandom_range(4));
    else if (pick < 99) len = 8'($urandom_range(20, 5));
    else len = 8'($urandom_range(40, 21));
    nack_at = ($urandom_range(99) < 15) ? $urandom_range(rd ? 4 : 3, 1) : 0;
    run_transaction(rd, 8'($urandom_range(255)), 8'($urandom_range(255)), len, nack_at,
                    $urandom_range(99) < 10, $urandom_range(99) < 5);
    repeat ($urandom_range(2)) push_random(KIND_TICK);
  endtask

  initial begin
    int phase_start;
    logic [6:0] phase_addr;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle ticks, latch extremes, zero and short reads, full-length read command,
    // nack aborts, address extremes
    push_item(KIND_TICK, pack_fields(1'b0, 8'h00, 8'h00, 8'h00, 1'b0));
    push_item(KIND_TICK, pack_fields(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    run_transaction(1'b0, 8'hFF, 8'h00, 8'h00, 0, 1'b0, 1'b0);
    busy_cmd_pct = 5;
    run_transaction(1'b0, 8'h00, 8'hFF, 8'hFF, 0, 1'b0, 1'b0);
    busy_cmd_pct = 0;
    run_transaction(1'b1, 8'h5A, 8'hA5, 8'd0, 0, 1'b0, 1'b0);
    run_transaction(1'b1, 8'hC3, 8'h3C, 8'd2, 0, 1'b0, 1'b1);
    run_transaction(1'b1, 8'h01, 8'h80, 8'd1, 0, 1'b0, 1'b0);
    run_transaction(1'b0, 8'h12, 8'h34, 8'd0, 1, 1'b0, 1'b0);
    run_transaction(1'b0, 8'h56, 8'h78, 8'd0, 2, 1'b0, 1'b0);
    run_transaction(1'b0, 8'h9A, 8'hBC, 8'd0, 3, 1'b0, 1'b0);
    run_transaction(1'b1, 8'hDE, 8'hF0, 8'd3, 4, 1'b0, 1'b0);
    wait_drained();
    write_address(7'h00);
    run_transaction(1'b1, 8'h77, 8'h11, 8'd3, 0, 1'b0, 1'b1);
    wait_drained();
    write_address(7'h7F);
    run_transaction(1'b0, 8'hAA, 8'h55, 8'd0, 0, 1'b0, 1'b0);
    run_transaction(1'b1, 8'h33, 8'hCC, 8'd255, 4, 1'b0, 1'b0);
    wait_drained();

    // random phases: no idling, sender idle, receiver stalls, both lightly
    busy_cmd_pct = 3;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  phase_addr = 7'h7F; end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  phase_addr = 7'h00; end
        2: begin
          send_idle_pct = 0; recv_stall_pct = 70; phase_addr = 7'($urandom_range(127));
        end
        default: begin
          send_idle_pct = 11; recv_stall_pct = 11; phase_addr = 7'($urandom_range(127));
        end
      endcase
      write_address(phase_addr);
      phase_start = txn_items;
      while (txn_items - phase_start < 60) begin
        random_transaction();
        if ($urandom_range(99) < 5) wait_drained();
      end
      wait_drained();
    end

    $display("run covered %0d transaction items in %0d transactions over four idle patterns",
             txn_items, txn_count);
    $display("%0d results checked, %0d stops seen, %0d of them nack aborts, %0d bytes read",
             results, dones, nacks, bytes_read);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
